### sv/tce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tce_pkg;

    // fixed-point formats
    localparam int FX_W     = 56;   // signed Q16.40
    localparam int FRAC_W   = 40;
    localparam int HALF_W   = 28;   // partial-product operand width
    localparam int PROD_W   = 112;  // full magnitude product
    localparam int IN_W     = 32;   // signed Q4.28
    localparam int IN_SHIFT = 12;   // Q4.28 -> Q16.40

    // register and result widths
    localparam int ITER_W     = 12;
    localparam int PER_W      = 5;
    localparam int EPS_W      = 32;
    localparam int EPS_SHIFT  = 8;  // 2^-32 units -> 2^-40 units
    localparam int RES_W      = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // parameter defaults
    localparam int ORBIT_DEPTH_DEF = 16;
    localparam int COUNT_BITS_DEF  = 12;

    // register reset values
    localparam int MAX_ITER_RESET   = 500;
    localparam int MAX_PERIOD_RESET = 10;
    localparam int EPS_SQ_RESET     = 429497;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS_SQ     = 2'd2;

    // result codes
    localparam int PERIOD_BASE = 128;
    localparam int PERIOD_STEP = 20;
    localparam logic [RES_W-1:0] RES_UNDECIDED = '1;

    typedef logic signed [FX_W-1:0] fx_t;

    localparam fx_t FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
    localparam fx_t FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

    // |z|^2 escape bound, 100 in Q16.40
    localparam logic [FX_W:0] ESC_LIMIT = (FX_W+1)'(100) << FRAC_W;

    typedef struct packed {
        logic [ITER_W-1:0] max_iter;
        logic [PER_W-1:0]  max_period;
        logic [EPS_W-1:0]  eps_sq;
    } cfg_t;

    typedef struct packed {
        logic start;
        fx_t  a;
        fx_t  b;
    } mul_req_t;

    typedef struct packed {
        logic done;
        fx_t  p;
    } mul_rsp_t;

    typedef struct packed {
        logic                    valid;
        logic signed [RES_W-1:0] code;
    } res_t;

    // clamp a sum or difference one bit wider than Q16.40 back into Q16.40
    function automatic fx_t sat_fx(input logic [FX_W:0] v);
        fx_t r;
        if (v[FX_W] != v[FX_W-1])
            r = v[FX_W] ? FX_MIN : FX_MAX;
        else
            r = fx_t'(v[FX_W-1:0]);
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/tce_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module tce_mul
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tce_pkg::mul_req_t req,
    output tce_pkg::mul_rsp_t      rsp
);

    localparam logic [2:0] PH_MUL_LAST = 3'd3;
    localparam logic [2:0] PH_LAST     = 3'd5;

    logic                          busy_reg, busy_next;
    logic [2:0]                    ph_reg, ph_next;
    logic                          pp_vld_reg, pp_vld_next;
    logic                          done_reg, done_next;
    logic [tce_pkg::FX_W-1:0]      ma_reg, ma_next;
    logic [tce_pkg::FX_W-1:0]      mb_reg, mb_next;
    logic                          neg_reg, neg_next;
    logic [2*tce_pkg::HALF_W-1:0]  pp_reg, pp_next;
    logic [1:0]                    pp_sh_reg, pp_sh_next;
    logic [tce_pkg::PROD_W-1:0]    acc_reg, acc_next;
    tce_pkg::fx_t                  p_reg, p_next;

    logic [tce_pkg::HALF_W-1:0]    a_half, b_half;
    logic [tce_pkg::PROD_W-1:0]    pp_shifted;
    logic [tce_pkg::FX_W-1:0]      mag;

    always_comb
    begin
        a_half = ph_reg[1] ? ma_reg[tce_pkg::FX_W-1:tce_pkg::HALF_W]
                           : ma_reg[tce_pkg::HALF_W-1:0];
        b_half = ph_reg[0] ? mb_reg[tce_pkg::FX_W-1:tce_pkg::HALF_W]
                           : mb_reg[tce_pkg::HALF_W-1:0];

        case (pp_sh_reg)
            2'd0:    pp_shifted = {{(2*tce_pkg::HALF_W){1'b0}}, pp_reg};
            2'd1:    pp_shifted = {{tce_pkg::HALF_W{1'b0}}, pp_reg, {tce_pkg::HALF_W{1'b0}}};
            2'd2:    pp_shifted = {pp_reg, {(2*tce_pkg::HALF_W){1'b0}}};
            default: pp_shifted = '0;
        endcase

        // product >> 40, clamped to the largest magnitude
        if (|acc_reg[tce_pkg::PROD_W-1:tce_pkg::FRAC_W+tce_pkg::FX_W-1])
            mag = tce_pkg::FX_MAX;
        else
            mag = {1'b0, acc_reg[tce_pkg::FRAC_W+tce_pkg::FX_W-2:tce_pkg::FRAC_W]};
    end

    always_comb
    begin
        busy_next   = busy_reg;
        ph_next     = ph_reg;
        pp_vld_next = 1'b0;
        done_next   = 1'b0;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        neg_next    = neg_reg;
        pp_next     = pp_reg;
        pp_sh_next  = pp_sh_reg;
        acc_next    = acc_reg;
        p_next      = p_reg;

        if (!busy_reg)
        begin
            if (req.start)
            begin
                ma_next   = req.a[tce_pkg::FX_W-1] ? (tce_pkg::FX_W'(0) - req.a) : req.a;
                mb_next   = req.b[tce_pkg::FX_W-1] ? (tce_pkg::FX_W'(0) - req.b) : req.b;
                neg_next  = req.a[tce_pkg::FX_W-1] ^ req.b[tce_pkg::FX_W-1];
                acc_next  = '0;
                ph_next   = '0;
                busy_next = 1'b1;
            end
        end
        else
        begin
            // one 28x28 partial product per cycle, added in the next
            if (ph_reg <= PH_MUL_LAST)
            begin
                pp_next     = {{tce_pkg::HALF_W{1'b0}}, a_half}
                            * {{tce_pkg::HALF_W{1'b0}}, b_half};
                pp_sh_next  = {1'b0, ph_reg[1]} + {1'b0, ph_reg[0]};
                pp_vld_next = 1'b1;
            end
            if (pp_vld_reg)
                acc_next = acc_reg + pp_shifted;
            if (ph_reg == PH_LAST)
            begin
                p_next    = neg_reg ? (tce_pkg::FX_W'(0) - mag) : mag;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                ph_next = ph_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ph_reg     <= '0;
            pp_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ph_reg     <= ph_next;
            pp_vld_reg <= pp_vld_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        neg_reg   <= neg_next;
        pp_reg    <= pp_next;
        pp_sh_reg <= pp_sh_next;
        acc_reg   <= acc_next;
        p_reg     <= p_next;
    end

    assign rsp.done = done_reg;
    assign rsp.p    = p_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("multiplier started while busy");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && ph_reg == PH_LAST) |=> (done_reg && !busy_reg))
        else $error("multiplier did not finish after last phase");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("multiplier done held longer than one cycle");

endmodule

`default_nettype wire

### sv/tce_core.sv
`timescale 1ns / 1ps
`default_nettype none

module tce_core
#(
    parameter int ORBIT_DEPTH = tce_pkg::ORBIT_DEPTH_DEF,
    parameter int COUNT_BITS  = tce_pkg::COUNT_BITS_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic signed [tce_pkg::IN_W-1:0]  c_re,
    input  wire logic signed [tce_pkg::IN_W-1:0]  c_im,
    input  wire tce_pkg::cfg_t                    cfg,
    input  wire logic                             res_ack,
    output logic                                  idle,
    output tce_pkg::res_t                         res,
    output tce_pkg::mul_req_t                     mul_req,
    input  wire tce_pkg::mul_rsp_t                mul_rsp
);

    localparam int CNT_W   = (COUNT_BITS < tce_pkg::ITER_W) ? COUNT_BITS : tce_pkg::ITER_W;
    localparam int OW      = (ORBIT_DEPTH > 1) ? $clog2(ORBIT_DEPTH) : 1;
    localparam int DEPTH_W = $clog2(ORBIT_DEPTH + 1);
    localparam int CMP_A   = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;
    localparam int CMP_W   = (CMP_A > tce_pkg::PER_W) ? CMP_A : tce_pkg::PER_W;
    localparam int FW      = tce_pkg::FX_W;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_CHECK = 13'b0000000000010,
        ST_MRI   = 13'b0000000000100,
        ST_UPD   = 13'b0000000001000,
        ST_SRE   = 13'b0000000010000,
        ST_MRR   = 13'b0000000100000,
        ST_MII   = 13'b0000001000000,
        ST_RD    = 13'b0000010000000,
        ST_DIFF  = 13'b0000100000000,
        ST_SDX   = 13'b0001000000000,
        ST_MDX   = 13'b0010000000000,
        ST_MDY   = 13'b0100000000000,
        ST_DONE  = 13'b1000000000000
    } state_t;

    state_t                          state_reg, state_next;
    tce_pkg::fx_t                    are_reg, are_next;
    tce_pkg::fx_t                    aim_reg, aim_next;
    tce_pkg::fx_t                    re_reg, re_next;
    tce_pkg::fx_t                    im_reg, im_next;
    tce_pkg::fx_t                    re2_reg, re2_next;
    tce_pkg::fx_t                    im2_reg, im2_next;
    tce_pkg::fx_t                    t_reg, t_next;
    tce_pkg::fx_t                    dx_reg, dx_next;
    tce_pkg::fx_t                    dy_reg, dy_next;
    tce_pkg::fx_t                    sq_reg, sq_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [CNT_W-1:0]                limit_reg, limit_next;
    logic [CNT_W-1:0]                from_reg, from_next;
    logic [tce_pkg::PER_W-1:0]       per_reg, per_next;
    logic [tce_pkg::PER_W-1:0]       j_reg, j_next;
    logic [OW-1:0]                   k_reg, k_next;
    logic [tce_pkg::RES_W-1:0]       code_reg, code_next;

    tce_pkg::fx_t                    orbit_re_mem [ORBIT_DEPTH];
    tce_pkg::fx_t                    orbit_im_mem [ORBIT_DEPTH];
    tce_pkg::fx_t                    rd_re_reg, rd_im_reg;
    logic                            wr_en;
    logic [OW-1:0]                   rd_addr;

    logic [CNT_W-1:0]                lim_cfg;
    logic [CMP_W-1:0]                per_c;
    logic [tce_pkg::PER_W-1:0]       per_eff;
    logic [FW:0]                     mag_sum;
    logic [FW:0]                     gap_sum;
    logic [FW:0]                     eps_th;

    // effective period: clamp to the iteration limit and the buffer depth
    always_comb
    begin
        lim_cfg = cfg.max_iter[CNT_W-1:0];
        per_c   = CMP_W'(cfg.max_period);
        if (per_c > CMP_W'(lim_cfg))
            per_c = CMP_W'(lim_cfg);
        if (per_c > CMP_W'(ORBIT_DEPTH))
            per_c = CMP_W'(ORBIT_DEPTH);
        per_eff = per_c[tce_pkg::PER_W-1:0];
    end

    assign mag_sum = {1'b0, re2_reg} + {1'b0, im2_reg};
    assign gap_sum = {1'b0, sq_reg} + {1'b0, mul_rsp.p};
    assign eps_th  = (FW+1)'({cfg.eps_sq, {tce_pkg::EPS_SHIFT{1'b0}}});
    // newest stored point first
    assign rd_addr = OW'(per_reg - j_reg - tce_pkg::PER_W'(1));

    always_comb
    begin
        state_next = state_reg;
        are_next   = are_reg;
        aim_next   = aim_reg;
        re_next    = re_reg;
        im_next    = im_reg;
        re2_next   = re2_reg;
        im2_next   = im2_reg;
        t_next     = t_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        sq_next    = sq_reg;
        cnt_next   = cnt_reg;
        limit_next = limit_reg;
        from_next  = from_reg;
        per_next   = per_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        code_next  = code_reg;
        wr_en      = 1'b0;
        mul_req.start = 1'b0;
        mul_req.a     = re_reg;
        mul_req.b     = im_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    are_next   = {{(FW-tce_pkg::IN_W-tce_pkg::IN_SHIFT){c_re[tce_pkg::IN_W-1]}},
                                  c_re, {tce_pkg::IN_SHIFT{1'b0}}};
                    aim_next   = {{(FW-tce_pkg::IN_W-tce_pkg::IN_SHIFT){c_im[tce_pkg::IN_W-1]}},
                                  c_im, {tce_pkg::IN_SHIFT{1'b0}}};
                    re_next    = '0;
                    im_next    = '0;
                    re2_next   = '0;
                    im2_next   = '0;
                    cnt_next   = '0;
                    k_next     = '0;
                    limit_next = lim_cfg;
                    per_next   = per_eff;
                    from_next  = lim_cfg - CNT_W'(per_eff);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (cnt_reg < limit_reg && mag_sum < tce_pkg::ESC_LIMIT)
                begin
                    // the last per_reg points before the iteration limit go to the buffer
                    if (cnt_reg >= from_reg)
                    begin
                        wr_en  = 1'b1;
                        k_next = k_reg + OW'(1);
                    end
                    mul_req.start = 1'b1;
                    state_next    = ST_MRI;
                end
                else if (cnt_reg >= limit_reg)
                begin
                    if (per_reg == '0)
                    begin
                        code_next  = tce_pkg::RES_UNDECIDED;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        j_next     = '0;
                        state_next = ST_RD;
                    end
                end
                else
                begin
                    code_next  = tce_pkg::RES_W'({cnt_reg, 1'b0});
                    state_next = ST_DONE;
                end
            end
            ST_MRI:
            begin
                if (mul_rsp.done)
                begin
                    t_next     = tce_pkg::sat_fx((FW+1)'(0) - {mul_rsp.p, 1'b0});
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                im_next    = tce_pkg::sat_fx({t_reg[FW-1], t_reg} + {aim_reg[FW-1], aim_reg});
                re_next    = tce_pkg::sat_fx({re2_reg[FW-1], re2_reg} - {im2_reg[FW-1], im2_reg}
                                             + {are_reg[FW-1], are_reg});
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = ST_SRE;
            end
            ST_SRE:
            begin
                mul_req.start = 1'b1;
                mul_req.b     = re_reg;
                state_next    = ST_MRR;
            end
            ST_MRR:
            begin
                if (mul_rsp.done)
                begin
                    re2_next      = mul_rsp.p;
                    mul_req.start = 1'b1;
                    mul_req.a     = im_reg;
                    state_next    = ST_MII;
                end
            end
            ST_MII:
            begin
                if (mul_rsp.done)
                begin
                    im2_next   = mul_rsp.p;
                    state_next = ST_CHECK;
                end
            end
            ST_RD:
            begin
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                dx_next    = tce_pkg::sat_fx({re_reg[FW-1], re_reg} - {rd_re_reg[FW-1], rd_re_reg});
                dy_next    = tce_pkg::sat_fx({im_reg[FW-1], im_reg} - {rd_im_reg[FW-1], rd_im_reg});
                state_next = ST_SDX;
            end
            ST_SDX:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = dx_reg;
                mul_req.b     = dx_reg;
                state_next    = ST_MDX;
            end
            ST_MDX:
            begin
                mul_req.a = dy_reg;
                mul_req.b = dy_reg;
                if (mul_rsp.done)
                begin
                    sq_next       = mul_rsp.p;
                    mul_req.start = 1'b1;
                    state_next    = ST_MDY;
                end
            end
            ST_MDY:
            begin
                if (mul_rsp.done)
                begin
                    if (gap_sum < eps_th)
                    begin
                        code_next  = tce_pkg::RES_W'(tce_pkg::PERIOD_BASE)
                                   + tce_pkg::RES_W'(tce_pkg::PERIOD_STEP)
                                   * tce_pkg::RES_W'(j_reg);
                        state_next = ST_DONE;
                    end
                    else if (j_reg == per_reg - tce_pkg::PER_W'(1))
                    begin
                        code_next  = tce_pkg::RES_UNDECIDED;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        j_next     = j_reg + tce_pkg::PER_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            ST_DONE:
            begin
                if (res_ack)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            limit_reg <= '0;
            from_reg  <= '0;
            per_reg   <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            limit_reg <= limit_next;
            from_reg  <= from_next;
            per_reg   <= per_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        are_reg  <= are_next;
        aim_reg  <= aim_next;
        re_reg   <= re_next;
        im_reg   <= im_next;
        re2_reg  <= re2_next;
        im2_reg  <= im2_next;
        t_reg    <= t_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        sq_reg   <= sq_next;
        code_reg <= code_next;
    end

    // orbit buffer, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            orbit_re_mem[k_reg] <= re_reg;
            orbit_im_mem[k_reg] <= im_reg;
        end
        rd_re_reg <= orbit_re_mem[rd_addr];
        rd_im_reg <= orbit_im_mem[rd_addr];
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res.valid = (state_reg == ST_DONE);
    assign res.code  = code_reg;

    a_write_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (CMP_W'(k_reg) < CMP_W'(per_reg)))
        else $error("orbit write beyond the checked period");

    a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == ST_MRI || state_reg == ST_MRR || state_reg == ST_MII
                          || state_reg == ST_MDX || state_reg == ST_MDY))
        else $error("product arrived outside a wait state");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> (cnt_reg <= limit_reg))
        else $error("step count ran past the iteration limit");

endmodule

`default_nettype wire

### sv/tricorn_escape_time_period.sv
// Tricorn escape-time evaluator with period detection.
// Input channel (in_valid/in_ready) takes one word: the point c as c_re, c_im
// in signed Q4.28. Output channel (out_valid/out_ready) returns one word per
// input: result_code = 2*count on escape, 128+20*j when the final z lies
// within eps_sq of the stored orbit point j (newest first), -1 otherwise.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// max_iter (0), max_period (1), eps_sq (2); cfg_ready is always high, and
// other indexes are ignored. Write registers only while the block is idle.
// One item at a time: in_ready is high only while the sequencer is idle.
// All products go through a single 28x28 multiplier: four partial products,
// accumulated as they arrive, then a step that clamps and signs the result.
// An iteration uses three products (re*im, re^2, im^2), and each period
// compare uses two squares (dx^2, dy^2), so the time an item takes grows
// with its number of iterations n and its number of compares m.
// A result sits in an output register; the next word is accepted while it
// waits, and a second result stalls the sequencer until out_ready frees it.
// Reset clears control state and restores max_iter 500, max_period 10 and
// eps_sq 429497; the orbit buffer needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module tricorn_escape_time_period
#(
    parameter int ORBIT_DEPTH = tce_pkg::ORBIT_DEPTH_DEF,
    parameter int COUNT_BITS  = tce_pkg::COUNT_BITS_DEF
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [tce_pkg::IN_W-1:0]        c_re,
    input  wire logic signed [tce_pkg::IN_W-1:0]        c_im,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [tce_pkg::RES_W-1:0]            result_code,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [tce_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [tce_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int CNT_W = (COUNT_BITS < tce_pkg::ITER_W) ? COUNT_BITS : tce_pkg::ITER_W;

    logic [CNT_W-1:0]                 max_iter_reg, max_iter_next;
    logic [tce_pkg::PER_W-1:0]        max_period_reg, max_period_next;
    logic [tce_pkg::EPS_W-1:0]        eps_sq_reg, eps_sq_next;
    logic                             out_valid_reg, out_valid_next;
    logic [tce_pkg::RES_W-1:0]        result_code_reg, result_code_next;

    tce_pkg::cfg_t                    cfg;
    tce_pkg::res_t                    res;
    tce_pkg::mul_req_t                mul_req;
    tce_pkg::mul_rsp_t                mul_rsp;
    logic                             core_idle;
    logic                             res_ack;

    assign cfg_ready = 1'b1;
    assign in_ready  = core_idle;
    // the output register can take a word when empty or being drained
    assign res_ack   = !out_valid_reg || out_ready;

    assign cfg.max_iter   = tce_pkg::ITER_W'(max_iter_reg);
    assign cfg.max_period = max_period_reg;
    assign cfg.eps_sq     = eps_sq_reg;

    always_comb
    begin
        max_iter_next   = max_iter_reg;
        max_period_next = max_period_reg;
        eps_sq_next     = eps_sq_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tce_pkg::CFG_MAX_ITER:   max_iter_next   = cfg_data[CNT_W-1:0];
                tce_pkg::CFG_MAX_PERIOD: max_period_next = cfg_data[tce_pkg::PER_W-1:0];
                tce_pkg::CFG_EPS_SQ:     eps_sq_next     = cfg_data[tce_pkg::EPS_W-1:0];
                default:                 max_iter_next   = max_iter_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        result_code_next = result_code_reg;
        if (res.valid && res_ack)
        begin
            out_valid_next   = 1'b1;
            result_code_next = res.code;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg   <= CNT_W'(tce_pkg::MAX_ITER_RESET);
            max_period_reg <= tce_pkg::PER_W'(tce_pkg::MAX_PERIOD_RESET);
            eps_sq_reg     <= tce_pkg::EPS_W'(tce_pkg::EPS_SQ_RESET);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            max_iter_reg   <= max_iter_next;
            max_period_reg <= max_period_next;
            eps_sq_reg     <= eps_sq_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_code_reg <= result_code_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_code = result_code_reg;

    tce_core
    #(
        .ORBIT_DEPTH (ORBIT_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    )
    u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_valid && in_ready),
        .c_re    (c_re),
        .c_im    (c_im),
        .cfg     (cfg),
        .res_ack (res_ack),
        .idle    (core_idle),
        .res     (res),
        .mul_req (mul_req),
        .mul_rsp (mul_rsp)
    );

    tce_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

endmodule

`default_nettype wire
